// ----- hw/rtl/cts_pkg.sv -----
package cts_pkg;

  // word layout on the stream channels
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 24;

  // configuration channel
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // fixed field widths
  localparam int unsigned TimerW    = 16;
  localparam int unsigned CountOutW = 16;
  localparam int unsigned CountWidthDefault = 16;

  // register reset values
  localparam logic [CfgDataW-1:0] DischargeTicksRst = 16'd500;
  localparam logic [CfgDataW-1:0] SettleTicksRst    = 16'd10;
  localparam logic [CfgDataW-1:0] MaxCountRst       = 16'd4095;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DISCHARGE_TICKS = 2'd0,
    CFG_SETTLE_TICKS    = 2'd1,
    CFG_MAX_COUNT       = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_DISCHARGE = 3'd1,
    PH_SETTLE    = 3'd2,
    PH_CHARGE    = 3'd3,
    PH_FLOAT     = 3'd4,
    PH_TRANSFER  = 3'd5,
    PH_SAMPLE    = 3'd6,
    PH_OPEN      = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    CT_FLOAT = 2'd0,
    CT_LOW   = 2'd1,
    CT_HIGH  = 2'd2
  } ct_mode_e;

  typedef struct packed {
    logic [CfgDataW-1:0] discharge_ticks;
    logic [CfgDataW-1:0] settle_ticks;
    logic [CfgDataW-1:0] max_count;
  } cfg_t;

  typedef struct packed {
    logic                 cs_drive_low;
    ct_mode_e             ct_mode;
    logic                 switches_closed;
    logic                 busy_res;
    logic                 done_res;
    logic                 timeout;
    logic [CountOutW-1:0] count;
  } res_t;

endpackage

// ----- hw/rtl/charge_transfer_touch_sequencer.sv -----
// Charge-transfer touch sequencer.
// s_axis carries one word per timing tick: start_req and the level read on the
// sampling pin. For every accepted word, m_axis returns exactly one word with
// the pin drive for that tick, busy, a one-word done pulse with the timeout
// flag and the transfer cycle count. The sequence is: discharge both
// capacitors, then repeat settle, charge, float, transfer, sample, open until
// the sampling pin reads high or max_count cycles have gone by.
// The cfg channel writes discharge_ticks (0), settle_ticks (1) and max_count
// (2); it is always ready and should only be used while no acquisition runs.
// An accepted word is held in the input register, then in the result register.
// Throughput is one word per cycle while m_axis does not stall: the input and
// result registers form a two-stage pipe with the sequencer logic between them.
// When m_axis stalls, one word waits in each register and s_axis_tready drops;
// the sequencer only steps when a word moves into the result register.
// Reset returns the sequencer to idle and the registers to their defaults.
module charge_transfer_touch_sequencer #(
  parameter int unsigned CountWidth = cts_pkg::CountWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] start_req, [1] sense_high
  input  logic [cts_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] cs_drive_low, [2:1] ct_mode, [3] switches_closed, [4] busy_res,
  // [5] done_res, [6] timeout, [22:7] count
  output logic [cts_pkg::OutTdataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cts_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cts_pkg::*;

  cfg_t cfg;
  res_t res;

  logic                 in_valid_q;
  logic                 start_q;
  logic                 sense_q;
  logic                 out_valid_q;
  logic [OutTdataW-1:0] out_data_q, out_data_d;
  logic                 step;
  logic                 in_take;

  cts_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cts_core #(
    .CountWidth (CountWidth)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (step),
    .start_req_i  (start_q),
    .sense_high_i (sense_q),
    .res_o        (res)
  );

  // a word moves on when the result register is free or being emptied
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign out_data_d = OutTdataW'({res.count, res.timeout, res.done_res, res.busy_res,
                                  res.switches_closed, res.ct_mode, res.cs_drive_low});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_take || (in_valid_q && !step);
      out_valid_q <= step || (out_valid_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      start_q <= s_axis_tdata[0];
      sense_q <= s_axis_tdata[1];
    end
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- hw/rtl/cts_cfg_regs.sv -----
module cts_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cts_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cts_pkg::CfgDataW-1:0] cfg_data_i,
  output cts_pkg::cfg_t                cfg_o
);
  import cts_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DISCHARGE_TICKS: cfg_d.discharge_ticks = cfg_data_i;
        CFG_SETTLE_TICKS:    cfg_d.settle_ticks    = cfg_data_i;
        CFG_MAX_COUNT:       cfg_d.max_count       = cfg_data_i;
        default:             cfg_d                 = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.discharge_ticks <= DischargeTicksRst;
      cfg_q.settle_ticks    <= SettleTicksRst;
      cfg_q.max_count       <= MaxCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/cts_core.sv -----
module cts_core #(
  parameter int unsigned CountWidth = cts_pkg::CountWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cts_pkg::cfg_t cfg_i,
  input  logic          step_i,
  input  logic          start_req_i,
  input  logic          sense_high_i,
  output cts_pkg::res_t res_o
);
  import cts_pkg::*;

  localparam logic [CountWidth-1:0] CountMax = '1;

  phase_e                phase_q, phase_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [TimerW-1:0]     timer_q, timer_d;
  logic                  full_q, full_d;

  logic [TimerW-1:0]     timer_next;
  logic [TimerW-1:0]     phase_len;
  logic                  timer_exp;
  logic [32:0]           count_ext;
  logic [32:0]           max_ext;
  logic                  limit_hit;
  logic                  acq_end;

  // one shared timer for the discharge and settle phases
  assign timer_next = timer_q + TimerW'(1);
  assign phase_len  = (phase_q == PH_DISCHARGE) ? cfg_i.discharge_ticks : cfg_i.settle_ticks;
  assign timer_exp  = (timer_next >= phase_len) || (timer_next == '0);

  assign count_ext = 33'(count_q);
  assign max_ext   = 33'(cfg_i.max_count);
  assign limit_hit = (count_ext >= max_ext) || (count_q == CountMax);
  assign acq_end   = full_q || limit_hit;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    timer_d = timer_q;
    full_d  = full_q;
    if (step_i) begin
      unique case (phase_q) inside
        PH_IDLE: begin
          if (start_req_i) begin
            count_d = '0;
            timer_d = '0;
            full_d  = 1'b0;
            phase_d = PH_DISCHARGE;
          end
        end
        PH_DISCHARGE, PH_SETTLE: begin
          if (timer_exp) begin
            timer_d = '0;
            phase_d = (phase_q == PH_DISCHARGE) ? PH_SETTLE : PH_CHARGE;
          end else begin
            timer_d = timer_next;
          end
        end
        PH_CHARGE:   phase_d = PH_FLOAT;
        PH_FLOAT:    phase_d = PH_TRANSFER;
        PH_TRANSFER: phase_d = PH_SAMPLE;
        PH_SAMPLE: begin
          if (sense_high_i) begin
            full_d = 1'b1;
          end else if (count_q != CountMax) begin
            count_d = count_q + CountWidth'(1);
          end
          phase_d = PH_OPEN;
        end
        PH_OPEN: begin
          timer_d = '0;
          if (acq_end) begin
            full_d  = 1'b0;
            count_d = '0;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_SETTLE;
          end
        end
      endcase
    end
  end

  // pin drive follows the phase held at the start of the tick
  always_comb begin
    res_o                 = '0;
    res_o.ct_mode         = CT_FLOAT;
    res_o.busy_res        = (phase_q != PH_IDLE);
    unique case (phase_q) inside
      PH_DISCHARGE: begin
        res_o.cs_drive_low = 1'b1;
        res_o.ct_mode      = CT_LOW;
      end
      PH_CHARGE:              res_o.ct_mode = CT_HIGH;
      PH_TRANSFER, PH_SAMPLE: res_o.switches_closed = 1'b1;
      PH_OPEN: begin
        if (acq_end) begin
          res_o.done_res = 1'b1;
          res_o.timeout  = !full_q;
          res_o.count    = count_ext[CountOutW-1:0];
        end
      end
      default: res_o.cs_drive_low = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      timer_q <= '0;
      full_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      timer_q <= timer_d;
      full_q  <= full_d;
    end
  end

`ifndef SYNTHESIS
  // idle always leaves a clean slate for the next start
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (count_q == '0 && !full_q && timer_q == '0))
    else $error("idle with stale acquisition state");

  // timer only runs in the timed phases
  a_timer_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (timer_q != '0) |-> (phase_q == PH_DISCHARGE || phase_q == PH_SETTLE))
    else $error("phase timer running outside a timed phase");

  // full is only known once a sample has been taken
  a_full_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (phase_q == PH_OPEN))
    else $error("full flag set outside open phase");

  // an ending step always returns to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.done_res) |=> (phase_q == PH_IDLE))
    else $error("acquisition ended without returning to idle");
`endif

endmodule

// ----- tb/sv/tb_charge_transfer_touch_sequencer.sv -----
`timescale 1ns / 100ps

module tb_charge_transfer_touch_sequencer;
  import cts_pkg::*;

  // one result word, packed as on m_axis_tdata[22:0]
  typedef struct packed {
    logic [CountOutW-1:0] cnt;
    logic                 tmo;
    logic                 done;
    logic                 busy;
    logic                 sw;
    logic [1:0]           ct;
    logic                 cs_low;
  } tick_t;

  typedef enum logic {
    DIR_TICK,
    DIR_REG
  } dir_kind_e;

  typedef struct packed {
    dir_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    logic                start;
    logic                sense;
    logic                typed;
    tick_t               want;
  } dir_row_t;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;
  localparam int unsigned PhaseWords = 96;
  localparam int unsigned NumPhases = 12;

  localparam tick_t IdleOut = '0;
  localparam tick_t DischargeOut = '{cnt: '0, tmo: 1'b0, done: 1'b0, busy: 1'b1,
                                     sw: 1'b0, ct: CT_LOW, cs_low: 1'b1};

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  // sequencer copy: registers and state
  logic [CfgDataW-1:0] discharge_len = DischargeTicksRst;
  logic [CfgDataW-1:0] settle_len = SettleTicksRst;
  logic [CfgDataW-1:0] count_limit = MaxCountRst;
  phase_e              seq_phase = PH_IDLE;
  logic [15:0]         xfer_count = '0;
  logic [TimerW-1:0]   phase_tmr = '0;
  logic                level_full = 1'b0;

  tick_t    tick_want_q [$];
  dir_row_t dir_rows [$];
  int       n_bad = 0;
  int       in_gap_pct = 8;
  int       out_stall_pct = 47;

  charge_transfer_touch_sequencer uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  // true when the timed phase has run its length; zero length acts as one
  function automatic logic phase_timer_done(input logic [TimerW-1:0] len);
    logic [TimerW-1:0] nxt;
    nxt = phase_tmr + TimerW'(1);
    if (nxt >= len || nxt == '0) begin
      phase_tmr = '0;
      return 1'b1;
    end
    phase_tmr = nxt;
    return 1'b0;
  endfunction

  function automatic tick_t advance_sequencer(input logic start, input logic sense);
    tick_t r;
    r = IdleOut;
    case (seq_phase)
      PH_IDLE: begin
        if (start) begin
          xfer_count = '0;
          phase_tmr = '0;
          level_full = 1'b0;
          seq_phase = PH_DISCHARGE;
        end
      end
      PH_DISCHARGE: begin
        r = DischargeOut;
        if (phase_timer_done(discharge_len)) seq_phase = PH_SETTLE;
      end
      PH_SETTLE: begin
        r.busy = 1'b1;
        if (phase_timer_done(settle_len)) seq_phase = PH_CHARGE;
      end
      PH_CHARGE: begin
        r.busy = 1'b1;
        r.ct = CT_HIGH;
        seq_phase = PH_FLOAT;
      end
      PH_FLOAT: begin
        r.busy = 1'b1;
        seq_phase = PH_TRANSFER;
      end
      PH_TRANSFER: begin
        r.busy = 1'b1;
        r.sw = 1'b1;
        seq_phase = PH_SAMPLE;
      end
      PH_SAMPLE: begin
        r.busy = 1'b1;
        r.sw = 1'b1;
        // a full read is never counted
        if (sense) level_full = 1'b1;
        else if (xfer_count != '1) xfer_count = xfer_count + 16'd1;
        seq_phase = PH_OPEN;
      end
      default: begin
        r.busy = 1'b1;
        if (level_full) begin
          r.done = 1'b1;
        end else if (xfer_count >= count_limit || xfer_count == '1) begin
          r.done = 1'b1;
          r.tmo = 1'b1;
        end
        phase_tmr = '0;
        if (r.done) begin
          r.cnt = xfer_count;
          level_full = 1'b0;
          xfer_count = '0;
          seq_phase = PH_IDLE;
        end else begin
          seq_phase = PH_SETTLE;
        end
      end
    endcase
    return r;
  endfunction

  function automatic tick_t ended(input logic tmo, input logic [CountOutW-1:0] cnt);
    tick_t r;
    r = IdleOut;
    r.busy = 1'b1;
    r.done = 1'b1;
    r.tmo = tmo;
    r.cnt = cnt;
    return r;
  endfunction

  function automatic dir_row_t tick_row(input logic start, input logic sense);
    return '{DIR_TICK, '0, '0, start, sense, 1'b0, IdleOut};
  endfunction

  function automatic dir_row_t typed_row(input logic start, input logic sense,
                                         input tick_t want);
    return '{DIR_TICK, '0, '0, start, sense, 1'b1, want};
  endfunction

  function automatic dir_row_t reg_row(input logic [CfgIdxW-1:0] idx,
                                       input logic [CfgDataW-1:0] val);
    return '{DIR_REG, idx, val, 1'b0, 1'b0, 1'b0, IdleOut};
  endfunction

  task automatic note_mismatch(input string msg);
    n_bad++;
    if (n_bad <= 10) $display("mismatch: %s", msg);
  endtask

  // one word on s_axis; the prediction is queued at the accepting edge
  task automatic send_tick(input logic start, input logic sense, input logic typed,
                           input tick_t want);
    tick_t pred;
    cfg_valid_i <= 1'b0;
    if ($urandom_range(99) < in_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InTdataW - 2){1'b0}}, sense, start};
    do @(posedge clk); while (!s_axis_tready);
    pred = advance_sequencer(start, sense);
    tick_want_q.push_back(typed ? want : pred);
  endtask

  // cfg_valid_i stays high after the write; the next word lowers it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (tick_want_q.size() != 0) @(posedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      CFG_DISCHARGE_TICKS: discharge_len = val;
      CFG_SETTLE_TICKS:    settle_len = val;
      CFG_MAX_COUNT:       count_limit = val;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin : check_results
    tick_t got;
    tick_t want;
    string diff;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[22:0];
      if (tick_want_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word %h", got));
      end else begin
        want = tick_want_q.pop_front();
        diff = "";
        if (got.cs_low !== want.cs_low) diff = {diff, " cs_drive_low"};
        if (got.ct !== want.ct) diff = {diff, " ct_mode"};
        if (got.sw !== want.sw) diff = {diff, " switches_closed"};
        if (got.busy !== want.busy) diff = {diff, " busy"};
        if (got.done !== want.done) diff = {diff, " done"};
        if (got.tmo !== want.tmo) diff = {diff, " timeout"};
        if (got.cnt !== want.cnt) diff = {diff, " count"};
        if (diff != "") begin
          note_mismatch($sformatf("%s: expected %h actual %h", diff, want, got));
        end
      end
    end
  end

  initial begin : stimulus
    logic [CfgDataW-1:0] disc;
    logic [CfgDataW-1:0] sett;
    logic [CfgDataW-1:0] lim;
    int unsigned         full_permil;
    int unsigned         busy_words;
    logic                start;
    logic                sense;

    // after reset, zero timing, zero max_count, unused index, start while busy
    dir_rows.push_back(typed_row(1'b0, 1'b0, IdleOut));
    dir_rows.push_back(typed_row(1'b0, 1'b1, IdleOut));
    dir_rows.push_back(reg_row(CFG_DISCHARGE_TICKS, 16'd0));
    dir_rows.push_back(reg_row(CFG_SETTLE_TICKS, 16'd0));
    dir_rows.push_back(reg_row(CFG_MAX_COUNT, 16'd0));
    dir_rows.push_back(reg_row(CfgIdxUnused, 16'hFFFF));
    dir_rows.push_back(typed_row(1'b1, 1'b1, IdleOut));
    dir_rows.push_back(typed_row(1'b1, 1'b0, DischargeOut));
    dir_rows.push_back(tick_row(1'b0, 1'b1));
    dir_rows.push_back(tick_row(1'b1, 1'b0));
    dir_rows.push_back(tick_row(1'b0, 1'b1));
    dir_rows.push_back(tick_row(1'b1, 1'b1));
    dir_rows.push_back(tick_row(1'b0, 1'b0));
    dir_rows.push_back(typed_row(1'b1, 1'b0, ended(1'b1, 16'd1)));
    // a transfer that reads low, then a transfer that reads full
    dir_rows.push_back(reg_row(CFG_MAX_COUNT, 16'hFFFF));
    dir_rows.push_back(reg_row(CFG_SETTLE_TICKS, 16'd1));
    dir_rows.push_back(reg_row(CFG_DISCHARGE_TICKS, 16'd2));
    dir_rows.push_back(typed_row(1'b1, 1'b0, IdleOut));
    dir_rows.push_back(typed_row(1'b0, 1'b0, DischargeOut));
    dir_rows.push_back(typed_row(1'b0, 1'b1, DischargeOut));
    for (int i = 0; i < 5; i++) dir_rows.push_back(tick_row(1'b0, 1'b0));
    dir_rows.push_back(tick_row(1'b1, 1'b1));
    for (int i = 0; i < 4; i++) dir_rows.push_back(tick_row(1'b1, 1'b0));
    dir_rows.push_back(tick_row(1'b0, 1'b1));
    dir_rows.push_back(typed_row(1'b0, 1'b0, ended(1'b0, 16'd1)));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == DIR_REG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_tick(dir_rows[i].start, dir_rows[i].sense, dir_rows[i].typed,
                  dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph / 4)
        0: begin
          in_gap_pct = 8;
          out_stall_pct = 47;
        end
        1: begin
          in_gap_pct = 47;
          out_stall_pct = 8;
        end
        default: begin
          in_gap_pct = 0;
          out_stall_pct = 0;
        end
      endcase
      if (ph == 8) begin
        disc = 16'd0;
        sett = 16'd0;
        lim = 16'd1;
      end else if (ph == 3) begin
        disc = 16'd1;
        sett = 16'd1;
        lim = 16'hFFFF;
      end else begin
        disc = CfgDataW'($urandom_range(12));
        sett = CfgDataW'($urandom_range(8));
        lim = CfgDataW'($urandom_range(24));
      end
      case ($urandom_range(2))
        0: full_permil = 30;
        1: full_permil = 150;
        default: full_permil = 500;
      endcase
      write_reg(CFG_DISCHARGE_TICKS, disc);
      write_reg(CFG_SETTLE_TICKS, sett);
      write_reg(CFG_MAX_COUNT, lim);

      busy_words = 0;
      while (busy_words < PhaseWords) begin
        if (seq_phase == PH_IDLE) start = ($urandom_range(99) < 85);
        else start = 1'($urandom_range(1));
        if (seq_phase == PH_SAMPLE) sense = ($urandom_range(999) < full_permil);
        else sense = 1'($urandom_range(1));
        if (seq_phase != PH_IDLE || start) busy_words++;
        send_tick(start, sense, 1'b0, IdleOut);
      end
      // finish the running acquisition so that registers can be rewritten
      while (seq_phase != PH_IDLE) send_tick(1'b0, 1'b1, 1'b0, IdleOut);
    end

    s_axis_tvalid <= 1'b0;
    while (tick_want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (n_bad == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/cts_pkg.sv
hw/rtl/cts_cfg_regs.sv
hw/rtl/cts_core.sv
hw/rtl/charge_transfer_touch_sequencer.sv
tb/sv/tb_charge_transfer_touch_sequencer.sv
